// ===== design/arp_pkg.sv =====
// Shared types and constants for the ARP cache resolver.
package arp_pkg;
    localparam logic [1:0] ACT_RAW   = 2'd0;
    localparam logic [1:0] ACT_REQ   = 2'd1;
    localparam logic [1:0] ACT_DATA  = 2'd2;
    localparam logic [1:0] ACT_REPLY = 2'd3;

    localparam logic [15:0] OPC_REQUEST = 16'd1;
    localparam logic [15:0] OPC_REPLY   = 16'd2;

    localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    localparam logic [2:0] REG_OWN_IP  = 3'd0;
    localparam logic [2:0] REG_OWN_MAC = 3'd1;
    localparam logic [2:0] REG_PROXY_A = 3'd2;
    localparam logic [2:0] REG_PROXY_B = 3'd3;
    localparam logic [2:0] REG_PROXY_C = 3'd4;
    localparam logic [2:0] REG_PROXY_D = 3'd5;
    localparam logic [2:0] REG_PROXY_EN = 3'd6;

    typedef struct packed {
        logic [1:0]  action;
        logic [47:0] dest_mac;
        logic [31:0] header_target_ip;
        logic [31:0] header_sender_ip;
        logic [15:0] sent_tag;
        logic        was_queued;
        logic        cache_full;
    } t_result;
endpackage

// ===== design/arp_cfg_regs.sv =====
// APB register file for the ARP cache resolver.
module arp_cfg_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic [31:0] o_own_ip,
    output logic [127:0] o_proxy_ip,
    output logic [3:0]  o_proxy_enable
);
    import arp_pkg::*;

    logic [31:0] r_own_ip;
    logic [47:0] r_own_mac;
    logic [31:0] r_proxy [4];
    logic [3:0]  r_proxy_en;
    logic [2:0]  w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip   <= '0;
            r_own_mac  <= '0;
            r_proxy    <= '{default: '0};
            r_proxy_en <= '0;
        end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
            unique case (w_idx)
                REG_OWN_IP:   r_own_ip   <= pwdata[31:0];
                REG_OWN_MAC:  r_own_mac  <= pwdata[47:0];
                REG_PROXY_A:  r_proxy[0] <= pwdata[31:0];
                REG_PROXY_B:  r_proxy[1] <= pwdata[31:0];
                REG_PROXY_C:  r_proxy[2] <= pwdata[31:0];
                REG_PROXY_D:  r_proxy[3] <= pwdata[31:0];
                REG_PROXY_EN: r_proxy_en <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_OWN_IP:   prdata = {32'd0, r_own_ip};
            REG_OWN_MAC:  prdata = {16'd0, r_own_mac};
            REG_PROXY_A:  prdata = {32'd0, r_proxy[0]};
            REG_PROXY_B:  prdata = {32'd0, r_proxy[1]};
            REG_PROXY_C:  prdata = {32'd0, r_proxy[2]};
            REG_PROXY_D:  prdata = {32'd0, r_proxy[3]};
            REG_PROXY_EN: prdata = {60'd0, r_proxy_en};
            default:      prdata = '0;
        endcase
    end

    assign o_own_ip       = r_own_ip;
    assign o_proxy_ip     = {r_proxy[3], r_proxy[2], r_proxy[1], r_proxy[0]};
    assign o_proxy_enable = r_proxy_en;
endmodule

// ===== design/arp_cache_resolver.sv =====
// Top level of the ARP cache resolver: cache scan, pending ring, result register.
//
// Input channel: i_valid/o_stall carry one event (send or received ARP) per beat.
// Output channel: o_valid/i_stall carry zero or one result per event.
// The cache (IP, MAC, resolved) lives in a memory with a registered read, scanned one
// entry per cycle; the pending ring is a second memory, read one slot at a time.
// A reply that hits the cache drains ring slots in order until one matches or the
// ring runs empty. Only one event is in work at a time: the next input beat is taken
// only after the result has been taken, and an event with no result frees the input
// when the block returns to idle.
// Reset clears the used bits, ring pointers and output valid; memories need no
// clearing. While the result register is full and i_stall is high, the block
// holds its result and keeps o_stall high until the result is taken.
// Registers sit on an APB port at 8-byte steps.
module arp_cache_resolver #(
    parameter int CACHE_ENTRIES = 8,
    parameter int QUEUE_SLOTS   = 8,
    parameter int PROXY_ENTRIES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [31:0] i_dest_ip,
    input  logic        i_has_payload,
    input  logic [15:0] i_packet_tag,
    input  logic        i_raw_broadcast,
    input  logic [15:0] i_arp_opcode,
    input  logic [31:0] i_sender_ip,
    input  logic [47:0] i_sender_mac,
    input  logic [31:0] i_target_ip,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_action,
    output logic [47:0] o_dest_mac,
    output logic [31:0] o_header_target_ip,
    output logic [31:0] o_header_sender_ip,
    output logic [15:0] o_sent_tag,
    output logic        o_was_queued,
    output logic        o_cache_full,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import arp_pkg::*;

    localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int QW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CCW = CW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DCHK  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [31:0]  own_ip;
    logic [127:0] proxy_ip;
    logic [3:0]   proxy_en;

    arp_cfg_regs u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_own_ip(own_ip), .o_proxy_ip(proxy_ip), .o_proxy_enable(proxy_en)
    );

    // cache memory
    logic [31:0] m_ip  [CACHE_ENTRIES];
    logic [47:0] m_mac [CACHE_ENTRIES];
    logic        m_res [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] r_used;
    logic [31:0] rd_ip;
    logic [47:0] rd_mac;
    logic        rd_res;

    // ring memory
    logic [31:0] q_ip  [QUEUE_SLOTS];
    logic [15:0] q_tag [QUEUE_SLOTS];
    logic [31:0] rq_ip;
    logic [15:0] rq_tag;
    logic [QW-1:0] r_head, r_tail;

    logic [2:0]  r_state;
    logic [2:0]  n_state;
    logic [CCW-1:0] r_cnt;
    logic [CW-1:0]  r_rd_idx;
    logic           r_rd_vld;
    logic           r_hit;
    logic [CW-1:0]  r_hit_idx;
    logic           r_hit_res;
    logic [47:0]    r_hit_mac;

    // latched event
    logic        r_op, r_pay, r_raw;
    logic [31:0] r_dip, r_sip, r_tip;
    logic [15:0] r_tag, r_opc;
    logic [47:0] r_smac;
    logic [31:0] key_ip;

    t_result r_res;
    t_result n_res;
    logic    r_ovld;

    // cache write port
    logic        cw_en;
    logic [CW-1:0] cw_idx;
    logic [31:0] cw_ip;
    logic [47:0] cw_mac;
    logic        cw_res;
    logic        cw_ipw;
    // ring write port
    logic        qw_en;
    logic [QW-1:0] qw_idx;
    logic [QW-1:0] q_rd_idx;

    logic        free_ok;
    logic [CW-1:0] free_idx;
    logic        is_proxy;
    logic [QW-1:0] tail_nx, head_nx;

    assign key_ip = r_op ? r_sip : r_dip;
    assign tail_nx = (r_tail == QW'(QUEUE_SLOTS - 1)) ? '0 : r_tail + 1'b1;
    assign head_nx = (r_head == QW'(QUEUE_SLOTS - 1)) ? '0 : r_head + 1'b1;

    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_ok  = 1'b1;
                free_idx = CW'(i);
            end
        end
    end

    always_comb begin
        is_proxy = 1'b0;
        for (int i = 0; i < PROXY_ENTRIES && i < 4; i++) begin
            if (proxy_en[i] && proxy_ip[32*i +: 32] == r_tip) is_proxy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        rd_ip  <= m_ip[r_cnt[CW-1:0]];
        rd_mac <= m_mac[r_cnt[CW-1:0]];
        rd_res <= m_res[r_cnt[CW-1:0]];
        if (cw_en) begin
            m_mac[cw_idx] <= cw_mac;
            m_res[cw_idx] <= cw_res;
            if (cw_ipw) m_ip[cw_idx] <= cw_ip;
        end
    end

    assign q_rd_idx = head_nx;
    always_ff @(posedge i_clk) begin
        rq_ip  <= q_ip[q_rd_idx];
        rq_tag <= q_tag[q_rd_idx];
        if (qw_en) begin
            q_ip[qw_idx]  <= r_dip;
            q_tag[qw_idx] <= r_tag;
        end
    end

    assign o_stall = (r_state != S_IDLE) || r_ovld;

    always_comb begin
        cw_en = 1'b0; cw_idx = r_hit_idx; cw_ip = key_ip; cw_mac = r_smac;
        cw_res = 1'b1; cw_ipw = 1'b0;
        qw_en = 1'b0; qw_idx = tail_nx;
        if (r_state == S_DEC) begin
            if (!r_op) begin
                if (!r_raw && !r_hit && free_ok) begin
                    cw_en = 1'b1; cw_idx = free_idx; cw_ipw = 1'b1;
                    cw_mac = '0; cw_res = 1'b0;
                end
                if (!r_raw && !(r_hit && r_hit_res) && (r_hit || free_ok) && r_pay
                    && tail_nx != r_head) qw_en = 1'b1;
            end else if (r_opc == OPC_REPLY && r_tip == own_ip) begin
                if (r_hit) cw_en = 1'b1;
            end else if (r_opc == OPC_REQUEST && (r_tip == own_ip || is_proxy)) begin
                if (r_hit) begin
                    cw_en = 1'b1; cw_res = r_hit_res;
                end else if (free_ok) begin
                    cw_en = 1'b1; cw_idx = free_idx; cw_ipw = 1'b1;
                end
            end
        end
    end

    // result and next state for the decision and drain-check steps
    always_comb begin
        n_res   = '0;
        n_state = S_IDLE;
        if (r_state == S_DCHK) begin
            n_res.action   = ACT_DATA;
            n_res.dest_mac = r_smac;
            n_res.sent_tag = rq_tag;
        end else if (!r_op) begin
            n_state = S_OUT;
            if (r_raw) begin
                n_res.action = ACT_RAW; n_res.dest_mac = BCAST_MAC;
                n_res.sent_tag = r_tag;
            end else if (r_hit && r_hit_res) begin
                if (r_pay) begin
                    n_res.action = ACT_DATA; n_res.dest_mac = r_hit_mac;
                    n_res.sent_tag = r_tag;
                end else begin
                    n_res.action = ACT_REQ; n_res.dest_mac = BCAST_MAC;
                    n_res.header_target_ip = r_dip;
                    n_res.header_sender_ip = own_ip;
                end
            end else begin
                n_res.action = ACT_REQ; n_res.dest_mac = BCAST_MAC;
                n_res.header_target_ip = r_dip;
                n_res.header_sender_ip = own_ip;
                n_res.cache_full = !r_hit && !free_ok;
                if (qw_en) begin
                    n_res.sent_tag = r_tag;
                    n_res.was_queued = 1'b1;
                end
            end
        end else if (r_opc == OPC_REPLY && r_tip == own_ip) begin
            if (r_hit) n_state = S_DRAIN;
        end else if (r_opc == OPC_REQUEST && (r_tip == own_ip || is_proxy)) begin
            n_res.action = ACT_REPLY; n_res.dest_mac = r_smac;
            n_res.header_target_ip = r_sip;
            n_res.header_sender_ip = r_tip;
            n_res.cache_full = !r_hit && !free_ok;
            n_state = S_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_ovld  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (r_ovld && !i_stall) r_ovld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !r_ovld) begin
                        r_op <= i_op; r_pay <= i_has_payload; r_raw <= i_raw_broadcast;
                        r_dip <= i_dest_ip; r_sip <= i_sender_ip; r_tip <= i_target_ip;
                        r_tag <= i_packet_tag; r_opc <= i_arp_opcode; r_smac <= i_sender_mac;
                        r_cnt <= '0; r_hit <= 1'b0; r_rd_vld <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // memory reads address r_cnt; data for r_rd_idx arrives now
                    r_rd_idx <= r_cnt[CW-1:0];
                    r_rd_vld <= (r_cnt != CCW'(CACHE_ENTRIES));
                    if (r_rd_vld && !r_hit && r_used[r_rd_idx] && rd_ip == key_ip) begin
                        r_hit <= 1'b1; r_hit_idx <= r_rd_idx;
                        r_hit_res <= rd_res; r_hit_mac <= rd_mac;
                    end
                    if (r_cnt == CCW'(CACHE_ENTRIES)) r_state <= S_DEC;
                    else r_cnt <= r_cnt + 1'b1;
                end
                S_DEC: begin
                    r_res   <= n_res;
                    r_state <= n_state;
                    if (cw_en && cw_ipw) r_used[cw_idx] <= 1'b1;
                    if (qw_en) r_tail <= tail_nx;
                end
                S_DRAIN: begin
                    // ring slot head+1 is being read
                    if (r_head == r_tail) r_state <= S_IDLE;
                    else r_state <= S_DCHK;
                end
                S_DCHK: begin
                    r_head <= head_nx;
                    if (rq_ip == r_sip) begin
                        r_res   <= n_res;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_OUT: begin
                    r_ovld  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid            = r_ovld;
    assign o_action           = r_res.action;
    assign o_dest_mac         = r_res.dest_mac;
    assign o_header_target_ip = r_res.header_target_ip;
    assign o_header_sender_ip = r_res.header_sender_ip;
    assign o_sent_tag         = r_res.sent_tag;
    assign o_was_queued       = r_res.was_queued;
    assign o_cache_full       = r_res.cache_full;
endmodule

// ===== dv/tb_arp_cache_resolver.sv =====
// Self-checking testbench for arp_cache_resolver: directed table, then random sends and ARP traffic.
module tb_arp_cache_resolver;
    timeunit 1ns;
    timeprecision 1ps;
    import arp_pkg::*;

    localparam int N_ENTRIES  = 8;
    localparam int N_SLOTS    = 8;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic        op;
        logic [31:0] dest_ip;
        logic        has_payload;
        logic [15:0] packet_tag;
        logic        raw_broadcast;
        logic [15:0] arp_opcode;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [31:0] target_ip;
    } t_arp_event;

    typedef struct {
        t_arp_event ev;
        bit         typed;
        bit         yields;
        t_result    res;
    } t_table_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic        i_op = 0;
    logic [31:0] i_dest_ip = 0;
    logic        i_has_payload = 0;
    logic [15:0] i_packet_tag = 0;
    logic        i_raw_broadcast = 0;
    logic [15:0] i_arp_opcode = 0;
    logic [31:0] i_sender_ip = 0;
    logic [47:0] i_sender_mac = 0;
    logic [31:0] i_target_ip = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [1:0]  o_action;
    logic [47:0] o_dest_mac;
    logic [31:0] o_header_target_ip;
    logic [31:0] o_header_sender_ip;
    logic [15:0] o_sent_tag;
    logic        o_was_queued;
    logic        o_cache_full;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [5:0]  paddr = 0;
    logic [63:0] pwdata = 0;
    logic [63:0] prdata;
    logic        pready;

    arp_cache_resolver u_top (.*);

    always #5 i_clk = ~i_clk;

    // resolver state mirror
    logic [31:0] cfg_own_ip;
    logic [47:0] cfg_own_mac;
    logic [31:0] cfg_proxy [4];
    logic [3:0]  cfg_proxy_en;
    bit          ent_used [N_ENTRIES];
    bit          ent_resolved [N_ENTRIES];
    logic [31:0] ent_ip [N_ENTRIES];
    logic [47:0] ent_mac [N_ENTRIES];
    logic [31:0] ring_ip [N_SLOTS];
    logic [15:0] ring_tag [N_SLOTS];
    logic [2:0]  ring_head, ring_tail;

    t_result    pending_results [$];
    t_table_row dir_rows [$];
    logic [31:0] ip_pool [12];
    bit         cur_typed, cur_yields;
    t_result    cur_res;
    int         errors, n_in, n_out, idle_cycles, tx_pct, rx_pct;
    int         n_req, n_reply, n_data, n_raw, n_full, n_queued;
    bit         hold_req;
    int         hold_cnt;

    function automatic int find_ip(logic [31:0] ip);
        for (int i = 0; i < N_ENTRIES; i++)
            if (ent_used[i] && ent_ip[i] == ip) return i;
        return -1;
    endfunction

    function automatic int find_free();
        for (int i = 0; i < N_ENTRIES; i++)
            if (!ent_used[i]) return i;
        return -1;
    endfunction

    function automatic t_result mk(logic [1:0] a, logic [47:0] m, logic [31:0] t,
                                   logic [31:0] s, logic [15:0] g, logic q, logic f);
        t_result r;
        r.action = a; r.dest_mac = m; r.header_target_ip = t; r.header_sender_ip = s;
        r.sent_tag = g; r.was_queued = q; r.cache_full = f;
        return r;
    endfunction

    function automatic bit resolve_event(t_arp_event ev, output t_result r);
        int e;
        bit full, queued, hit;
        r = mk(ACT_RAW, 0, 0, 0, 0, 0, 0);
        full = 0; queued = 0; hit = 0;
        if (!ev.op) begin
            if (ev.raw_broadcast) begin
                r = mk(ACT_RAW, BCAST_MAC, 0, 0, ev.packet_tag, 0, 0);
                return 1;
            end
            e = find_ip(ev.dest_ip);
            if (e >= 0 && ent_resolved[e]) begin
                if (ev.has_payload) r = mk(ACT_DATA, ent_mac[e], 0, 0, ev.packet_tag, 0, 0);
                else r = mk(ACT_REQ, BCAST_MAC, ev.dest_ip, cfg_own_ip, 0, 0, 0);
                return 1;
            end
            if (e < 0) begin
                e = find_free();
                if (e < 0) full = 1;
                else begin
                    ent_used[e] = 1; ent_resolved[e] = 0;
                    ent_ip[e] = ev.dest_ip; ent_mac[e] = 0;
                end
            end
            if (!full && ev.has_payload && ring_tail + 3'd1 != ring_head) begin
                ring_tail = ring_tail + 3'd1;
                ring_ip[ring_tail] = ev.dest_ip;
                ring_tag[ring_tail] = ev.packet_tag;
                queued = 1;
            end
            r = mk(ACT_REQ, BCAST_MAC, ev.dest_ip, cfg_own_ip,
                   queued ? ev.packet_tag : 16'd0, queued, full);
            return 1;
        end
        if (ev.arp_opcode == OPC_REPLY && ev.target_ip == cfg_own_ip) begin
            e = find_ip(ev.sender_ip);
            if (e < 0) return 0;
            ent_mac[e] = ev.sender_mac;
            ent_resolved[e] = 1;
            while (ring_head != ring_tail) begin
                ring_head = ring_head + 3'd1;
                if (ring_ip[ring_head] == ent_ip[e]) begin
                    r = mk(ACT_DATA, ev.sender_mac, 0, 0, ring_tag[ring_head], 0, 0);
                    return 1;
                end
            end
            return 0;
        end
        for (int i = 0; i < 4; i++)
            if (cfg_proxy_en[i] && cfg_proxy[i] == ev.target_ip) hit = 1;
        if (ev.arp_opcode == OPC_REQUEST && (ev.target_ip == cfg_own_ip || hit)) begin
            e = find_ip(ev.sender_ip);
            if (e < 0) begin
                e = find_free();
                if (e < 0) full = 1;
                else begin
                    ent_used[e] = 1; ent_resolved[e] = 1;
                    ent_ip[e] = ev.sender_ip; ent_mac[e] = ev.sender_mac;
                end
            end else ent_mac[e] = ev.sender_mac;
            r = mk(ACT_REPLY, ev.sender_mac, ev.sender_ip, ev.target_ip, 0, 0, full);
            return 1;
        end
        return 0;
    endfunction

    // input side: predict on every accepted beat
    always @(posedge i_clk) begin
        t_result r;
        bit y;
        if (i_rst_n && i_valid && !o_stall) begin
            t_arp_event ev;
            ev.op = i_op; ev.dest_ip = i_dest_ip; ev.has_payload = i_has_payload;
            ev.packet_tag = i_packet_tag; ev.raw_broadcast = i_raw_broadcast;
            ev.arp_opcode = i_arp_opcode; ev.sender_ip = i_sender_ip;
            ev.sender_mac = i_sender_mac; ev.target_ip = i_target_ip;
            y = resolve_event(ev, r);
            if (cur_typed) begin
                if (y != cur_yields) begin
                    $error("directed row: result presence expected %0d predicted %0d",
                           cur_yields, y);
                    errors++;
                end
                y = cur_yields;
                r = cur_res;
            end
            if (y) pending_results.push_back(r);
            n_in++;
        end
    end

    function automatic void cmp(string name, logic [47:0] e, logic [47:0] a);
        if (e !== a) begin
            $error("%s: expected %h actual %h", name, e, a);
            errors++;
        end
    endfunction

    // output side
    always @(posedge i_clk) begin
        t_result x;
        if (i_rst_n && o_valid && !i_stall) begin
            n_out++;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                x = pending_results.pop_front();
                cmp("action", x.action, o_action);
                cmp("dest_mac", x.dest_mac, o_dest_mac);
                cmp("header_target_ip", x.header_target_ip, o_header_target_ip);
                cmp("header_sender_ip", x.header_sender_ip, o_header_sender_ip);
                cmp("sent_tag", x.sent_tag, o_sent_tag);
                cmp("was_queued", x.was_queued, o_was_queued);
                cmp("cache_full", x.cache_full, o_cache_full);
                case (x.action)
                    ACT_RAW:  n_raw++;
                    ACT_REQ:  n_req++;
                    ACT_DATA: n_data++;
                    default:  n_reply++;
                endcase
                if (x.cache_full) n_full++;
                if (x.was_queued) n_queued++;
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_cnt = 300;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_stall <= 1'b1;
        end else i_stall <= ($urandom_range(99) < rx_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_OWN_IP:  cfg_own_ip = val[31:0];
            REG_OWN_MAC: cfg_own_mac = val[47:0];
            REG_PROXY_A: cfg_proxy[0] = val[31:0];
            REG_PROXY_B: cfg_proxy[1] = val[31:0];
            REG_PROXY_C: cfg_proxy[2] = val[31:0];
            REG_PROXY_D: cfg_proxy[3] = val[31:0];
            default:     cfg_proxy_en = val[3:0];
        endcase
    endtask

    task automatic drain();
        wait (pending_results.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic configure(logic [31:0] ip, logic [47:0] mac, logic [31:0] pa,
                             logic [31:0] pb, logic [31:0] pc, logic [31:0] pd, logic [3:0] en);
        drain();
        apb_write(REG_OWN_IP, 64'(ip));
        apb_write(REG_OWN_MAC, 64'(mac));
        apb_write(REG_PROXY_A, 64'(pa));
        apb_write(REG_PROXY_B, 64'(pb));
        apb_write(REG_PROXY_C, 64'(pc));
        apb_write(REG_PROXY_D, 64'(pd));
        apb_write(REG_PROXY_EN, 64'(en));
    endtask

    task automatic send_beat(t_arp_event ev, bit typed, bit yields, t_result r, bit no_gap);
        int gap;
        gap = 0;
        if (!no_gap) while ($urandom_range(99) < tx_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        cur_typed <= typed; cur_yields <= yields; cur_res <= r;
        i_valid <= 1;
        i_op <= ev.op; i_dest_ip <= ev.dest_ip; i_has_payload <= ev.has_payload;
        i_packet_tag <= ev.packet_tag; i_raw_broadcast <= ev.raw_broadcast;
        i_arp_opcode <= ev.arp_opcode; i_sender_ip <= ev.sender_ip;
        i_sender_mac <= ev.sender_mac; i_target_ip <= ev.target_ip;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic t_arp_event ev_send(logic [31:0] ip, logic pl, logic [15:0] tag, logic raw);
        t_arp_event ev;
        ev = '{default: '0};
        ev.dest_ip = ip; ev.has_payload = pl; ev.packet_tag = tag; ev.raw_broadcast = raw;
        return ev;
    endfunction

    function automatic t_arp_event ev_arp(logic [15:0] opc, logic [31:0] sip, logic [47:0] smac,
                                         logic [31:0] tip);
        t_arp_event ev;
        ev = '{default: '0};
        ev.op = 1; ev.arp_opcode = opc; ev.sender_ip = sip; ev.sender_mac = smac;
        ev.target_ip = tip;
        return ev;
    endfunction

    function automatic void add_row(t_arp_event ev);
        t_table_row row;
        row.ev = ev; row.typed = 0; row.yields = 0; row.res = mk(ACT_RAW, 0, 0, 0, 0, 0, 0);
        dir_rows.push_back(row);
    endfunction

    function automatic void add_typed(t_arp_event ev, bit y, t_result r);
        t_table_row row;
        row.ev = ev; row.typed = 1; row.yields = y; row.res = r;
        dir_rows.push_back(row);
    endfunction

    function automatic t_arp_event rand_event();
        t_arp_event ev;
        int k;
        ev.op = 1'($urandom); ev.dest_ip = $urandom; ev.has_payload = 1'($urandom);
        ev.packet_tag = 16'($urandom); ev.raw_broadcast = 1'($urandom);
        ev.arp_opcode = 16'($urandom); ev.sender_ip = $urandom;
        ev.sender_mac = 48'({$urandom, $urandom}); ev.target_ip = $urandom;
        k = $urandom_range(99);
        if (k < 38) begin
            ev.op = 0;
            ev.dest_ip = ip_pool[$urandom_range(11)];
            ev.has_payload = ($urandom_range(9) < 8);
            ev.raw_broadcast = ($urandom_range(9) == 0);
        end else if (k < 62) begin
            ev.op = 1;
            ev.arp_opcode = OPC_REPLY;
            ev.sender_ip = ip_pool[$urandom_range(11)];
            if ($urandom_range(9) != 0) ev.target_ip = cfg_own_ip;
        end else if (k < 85) begin
            ev.op = 1;
            ev.arp_opcode = OPC_REQUEST;
            if ($urandom_range(4) != 0) ev.sender_ip = ip_pool[$urandom_range(11)];
            k = $urandom_range(5);
            if (k < 4) ev.target_ip = cfg_proxy[k];
            else if (k == 4) ev.target_ip = cfg_own_ip;
        end
        return ev;
    endfunction

    initial begin
        t_result none;
        none = mk(ACT_RAW, 0, 0, 0, 0, 0, 0);
        errors = 0; n_in = 0; n_out = 0; idle_cycles = 0; tx_pct = 0; rx_pct = 0;
        n_req = 0; n_reply = 0; n_data = 0; n_raw = 0; n_full = 0; n_queued = 0;
        hold_req = 0; hold_cnt = 0;
        cfg_own_ip = 0; cfg_own_mac = 0; cfg_proxy_en = 0;
        for (int i = 0; i < 4; i++) cfg_proxy[i] = 0;
        for (int i = 0; i < N_ENTRIES; i++) ent_used[i] = 0;
        ring_head = 0; ring_tail = 0;
        ip_pool[0] = 32'h0; ip_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 12; i++) ip_pool[i] = $urandom;

        // reset values: own_ip is zero
        add_typed(ev_send(32'h1, 1, 16'hFFFF, 1), 1,
                  mk(ACT_RAW, BCAST_MAC, 0, 0, 16'hFFFF, 0, 0));
        add_typed(ev_send(32'hFFFF_FFFF, 0, 16'h0, 1), 1, mk(ACT_RAW, BCAST_MAC, 0, 0, 0, 0, 0));
        add_typed(ev_send(32'hFFFF_FFFF, 1, 16'h1234, 0), 1,
                  mk(ACT_REQ, BCAST_MAC, 32'hFFFF_FFFF, 0, 16'h1234, 1, 0));
        add_typed(ev_send(32'hFFFF_FFFF, 0, 16'h5555, 0), 1,
                  mk(ACT_REQ, BCAST_MAC, 32'hFFFF_FFFF, 0, 0, 0, 0));
        add_typed(ev_send(32'h0, 1, 16'hABCD, 0), 1,
                  mk(ACT_REQ, BCAST_MAC, 0, 0, 16'hABCD, 1, 0));
        add_typed(ev_arp(OPC_REPLY, 32'h7, 48'h1, 32'h0), 0, none);
        add_typed(ev_arp(OPC_REPLY, 32'h0, 48'h1, 32'h5), 0, none);
        add_typed(ev_arp(16'hFFFF, 32'h0, 48'h1, 32'h0), 0, none);
        add_typed(ev_arp(16'h0, 32'h0, 48'h1, 32'h0), 0, none);
        add_row(ev_arp(OPC_REPLY, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0));
        add_row(ev_send(32'hFFFF_FFFF, 1, 16'h0001, 0));
        add_row(ev_send(32'hFFFF_FFFF, 0, 16'h0002, 0));
        add_typed(ev_arp(OPC_REQUEST, 32'hC0A8_0001, 48'h0, 32'h9), 0, none);
        add_typed(ev_arp(OPC_REQUEST, 32'hC0A8_0001, 48'hFFFF_FFFF_FFFF, 32'h0), 1,
                  mk(ACT_REPLY, BCAST_MAC, 32'hC0A8_0001, 0, 0, 0, 0));
        add_row(ev_arp(OPC_REPLY, 32'h0, 48'h0000_0000_0001, 32'h0));
        add_row(ev_arp(OPC_REPLY, 32'h0, 48'h0000_0000_0002, 32'h0));
        // fill the cache, then overflow it; repeats fill the ring
        for (int i = 0; i < 8; i++)
            add_row(ev_send(32'(32'h0A00_0001 + i), 1, 16'(16'h100 + i), 0));
        for (int i = 0; i < 3; i++)
            add_row(ev_send(32'(32'h0A00_0001 + i), 1, 16'(16'h200 + i), 0));
        add_row(ev_arp(OPC_REQUEST, 32'h0B00_0001, 48'h12, 32'h0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (dir_rows[i]) send_beat(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].yields,
                                        dir_rows[i].res, 0);
        i_valid <= 0;

        for (int ph = 0; ph < 4; ph++) begin
            rx_pct = 0;
            case (ph)
                0: configure(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, ip_pool[2], ip_pool[3],
                             ip_pool[4], 32'hFFFF_FFFF, 4'hF);
                1: configure(32'h0, 48'h0, 32'h0, ip_pool[5], ip_pool[6], ip_pool[7], 4'h0);
                default: configure(ip_pool[$urandom_range(11)], 48'({$urandom, $urandom}),
                                   ip_pool[$urandom_range(11)], ip_pool[$urandom_range(11)],
                                   $urandom, ip_pool[$urandom_range(11)], 4'($urandom));
            endcase
            tx_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 63 : 23) : 0;
            rx_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 63 : 23) : 0;
            if (ph == 0) begin
                hold_req = 1;
                @(posedge i_clk);
                for (int i = 0; i < 6; i++) send_beat(rand_event(), 0, 0, none, 1);
            end
            for (int i = 0; i < 420; i++) begin
                send_beat(rand_event(), 0, 0, none, (i % 100) < 20);
                if (i == 200) begin
                    i_valid <= 0;
                    drain();
                end
            end
            i_valid <= 0;
        end

        rx_pct = 0;
        wait (pending_results.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("%0d events in, %0d results out over 5 register settings", n_in, n_out);
        $display("raw %0d, request %0d, data %0d, reply %0d, queued %0d, cache full %0d",
                 n_raw, n_req, n_data, n_reply, n_queued, n_full);
        if (errors == 0 && pending_results.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
